// ----- rtl/sstat_pkg.sv -----
// ----------------------------------------------------------------------------
// sstat_pkg
// Shared types and constants of the sample statistics block.
// ----------------------------------------------------------------------------
package sstat_pkg;

  // Default build parameters
  localparam int MAX_COUNT_DEF    = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed field widths of the stream channels
  localparam int SAMPLE_W    = 16;
  localparam int RES_W       = 16;
  localparam int VAR_W       = 32;
  localparam int S_TDATA_W   = SAMPLE_W;
  localparam int M_TDATA_W   = 4 * RES_W + VAR_W;

  // Configuration register
  localparam int            CNT_W      = 11;
  localparam int            CNT_HW_MAX = (2 ** CNT_W) - 1;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(5);
  localparam int            CFG_ADDR_W = 3;
  localparam int            CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] CFG_IDX_SAMPLE_COUNT = '0;

  // Square root: one result bit from two radicand bits per step
  localparam int               SQRT_STEPS = VAR_W / 2;
  localparam logic [VAR_W-1:0] SQRT_BIT0  = VAR_W'(1) << (VAR_W - 2);

  typedef enum logic [7:0] {
    S_ACC   = 8'b0000_0001,
    S_PROD  = 8'b0000_0010,
    S_MDIV  = 8'b0000_0100,
    S_VLOAD = 8'b0000_1000,
    S_VDIV  = 8'b0001_0000,
    S_SLOAD = 8'b0010_0000,
    S_SQRT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } sstat_state_e;

  typedef struct packed {
    logic accum;      // fold accepted sample into the set
    logic prod;       // register the final products
    logic ld_mean;    // load divider with |sum| / n
    logic div_step;   // one restoring-division step
    logic cap_mean;   // capture signed mean from quotient
    logic ld_var;     // load divider with variance numerator / denominator
    logic sqrt_ld;    // capture variance, start square root
    logic sqrt_step;  // one square-root step
    logic out_ld;     // load output register, clear the set
  } sstat_cmd_t;

  typedef struct packed {
    logic last;       // accepting a sample now completes the set
    logic out_free;   // output register can take a new result
  } sstat_sts_t;

endpackage

// ----- rtl/sstat_ctrl.sv -----
// ----------------------------------------------------------------------------
// sstat_ctrl
// Sequencer: accumulate phase, then mean divide, variance divide, square root
// and result hand-off, driving the datapath through command strobes.
// ----------------------------------------------------------------------------
module sstat_ctrl #(
  parameter int SAMPLE_WIDTH = sstat_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sstat_pkg::sstat_sts_t sts_i,
  output sstat_pkg::sstat_cmd_t cmd_o
);
  import sstat_pkg::*;

  localparam int QB        = 2 * SAMPLE_WIDTH - 1;
  localparam int ITERS_MAX = (QB > SQRT_STEPS) ? QB : SQRT_STEPS;
  localparam int CW        = $clog2(ITERS_MAX);
  localparam logic [CW-1:0] DIV_LAST  = CW'(QB - 1);
  localparam logic [CW-1:0] SQRT_LAST = CW'(SQRT_STEPS - 1);

  sstat_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_ACC);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_ACC: begin
        cmd_o.accum = in_valid_i;
        if (in_valid_i && sts_i.last) begin
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.prod    = 1'b1;
        cmd_o.ld_mean = 1'b1;
        cnt_d         = '0;
        state_d       = S_MDIV;
      end
      S_MDIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = S_VLOAD;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_VLOAD: begin
        cmd_o.cap_mean = 1'b1;
        cmd_o.ld_var   = 1'b1;
        state_d        = S_VDIV;
      end
      S_VDIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = S_SLOAD;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_SLOAD: begin
        cmd_o.sqrt_ld = 1'b1;
        state_d       = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == SQRT_LAST) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_DONE: begin
        // previous result may still be waiting downstream
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/sstat_dp.sv -----
// ----------------------------------------------------------------------------
// sstat_dp
// Datapath: set accumulators, final products, shared restoring divider,
// digit-by-digit square root and the output register.
// ----------------------------------------------------------------------------
module sstat_dp #(
  parameter int MAX_COUNT    = sstat_pkg::MAX_COUNT_DEF,
  parameter int SAMPLE_WIDTH = sstat_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [sstat_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [sstat_pkg::CNT_W-1:0]    sample_count_i,
  input  sstat_pkg::sstat_cmd_t          cmd_i,
  output sstat_pkg::sstat_sts_t          sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sstat_pkg::RES_W-1:0]    mean_o,
  output logic [sstat_pkg::RES_W-1:0]    minimum_o,
  output logic [sstat_pkg::RES_W-1:0]    maximum_o,
  output logic [sstat_pkg::VAR_W-1:0]    variance_o,
  output logic [sstat_pkg::RES_W-1:0]    std_dev_o
);
  import sstat_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CAP  = (MAX_COUNT < CNT_HW_MAX) ? MAX_COUNT : CNT_HW_MAX;
  localparam int NW   = $clog2(CAP + 1);
  localparam int SUMW = SW + NW;
  localparam int SQW  = 2 * SW - 2 + NW;
  localparam int NUMW = SQW + NW;
  localparam int DENW = 2 * NW;
  localparam int QB   = 2 * SW - 1;   // quotient bits; both quotients fit

  // ---------------- sample decode ----------------
  logic [SW+SAMPLE_W-1:0] smp_wide;
  logic signed [SW-1:0]   x;
  logic [SW-1:0]          x_mag;
  logic [2*SW-1:0]        x_sq;

  assign smp_wide = {{SW{1'b0}}, sample_i};
  assign x        = signed'(smp_wide[SW-1:0]);
  assign x_mag    = x[SW-1] ? SW'(-x) : SW'(x);
  assign x_sq     = (2 * SW)'(x_mag) * (2 * SW)'(x_mag);

  // ---------------- set accumulators ----------------
  logic [NW-1:0]          seen_q;
  logic signed [SUMW-1:0] sum_q;
  logic [SQW-1:0]         sumsq_q;
  logic signed [SW-1:0]   lo_q, hi_q;
  logic                   first;

  assign first = (seen_q == '0);

  // ---------------- set size ----------------
  logic [NW-1:0] tgt;

  always_comb begin
    if (sample_count_i < CNT_W'(2)) begin
      tgt = NW'(2);
    end else if (32'(sample_count_i) > 32'(CAP)) begin
      tgt = NW'(CAP);
    end else begin
      tgt = NW'(sample_count_i);
    end
  end

  assign sts_o.last = ({1'b0, seen_q} + (NW + 1)'(1)) >= {1'b0, tgt};

  // ---------------- final products ----------------
  logic [SUMW-1:0]   sum_mag;
  logic [2*SUMW-1:0] sum_sq;
  logic [NUMW-1:0]   p1_q, p2_q;
  logic [DENW-1:0]   den_q;
  logic              neg;

  assign neg     = sum_q[SUMW-1];
  assign sum_mag = neg ? SUMW'(-sum_q) : SUMW'(sum_q);
  assign sum_sq  = (2 * SUMW)'(sum_mag) * (2 * SUMW)'(sum_mag);

  // ---------------- shared divider ----------------
  logic [NUMW-1:0] dvd;
  logic [DENW-1:0] dvs;
  logic [DENW-1:0] rem_q;
  logic [DENW-1:0] dvs_q;
  logic [QB-1:0]   dq_q;
  logic [DENW:0]   rem_sh;
  logic [DENW:0]   rem_sub;
  logic            ge;

  assign dvd = cmd_i.ld_var ? (p1_q - p2_q) : NUMW'(sum_mag);
  assign dvs = cmd_i.ld_var ? den_q : DENW'(seen_q);

  assign rem_sh  = {rem_q, dq_q[QB-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // ---------------- mean ----------------
  logic [QB+RES_W-1:0] q_ext, q_sgn;
  logic [RES_W-1:0]    mean_q;

  assign q_ext = (QB + RES_W)'(dq_q);
  assign q_sgn = neg ? (QB + RES_W)'(-q_ext) : q_ext;

  // ---------------- square root ----------------
  logic [VAR_W-1:0] var_q, sv_q, sr_q, sb_q, s_try;
  logic             s_ge;

  assign s_try = sr_q + sb_q;
  assign s_ge  = sv_q >= s_try;

  // ---------------- output register ----------------
  logic             out_valid_q;
  logic [RES_W-1:0] o_mean_q, o_min_q, o_max_q, o_sd_q;
  logic [VAR_W-1:0] o_var_q;
  logic [SW+RES_W-1:0] lo_ext, hi_ext;

  assign lo_ext         = {{RES_W{lo_q[SW-1]}}, lo_q};
  assign hi_ext         = {{RES_W{hi_q[SW-1]}}, hi_q};
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign mean_o      = o_mean_q;
  assign minimum_o   = o_min_q;
  assign maximum_o   = o_max_q;
  assign variance_o  = o_var_q;
  assign std_dev_o   = o_sd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      sum_q       <= '0;
      sumsq_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accum) begin
        seen_q  <= seen_q + NW'(1);
        sum_q   <= sum_q + SUMW'(x);
        sumsq_q <= sumsq_q + SQW'(x_sq);
      end else if (cmd_i.out_ld) begin
        seen_q  <= '0;
        sum_q   <= '0;
        sumsq_q <= '0;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      if (first || (x < lo_q)) begin
        lo_q <= x;
      end
      if (first || (x > hi_q)) begin
        hi_q <= x;
      end
    end
    if (cmd_i.prod) begin
      p1_q  <= NUMW'(seen_q) * NUMW'(sumsq_q);
      p2_q  <= sum_sq[NUMW-1:0];
      den_q <= DENW'(seen_q) * DENW'(seen_q - NW'(1));
    end
    if (cmd_i.ld_mean || cmd_i.ld_var) begin
      // top part of the dividend is below the divisor, so only QB steps remain
      rem_q <= DENW'(dvd[NUMW-1:QB]);
      dq_q  <= dvd[QB-1:0];
      dvs_q <= dvs;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
      dq_q  <= {dq_q[QB-2:0], ge};
    end
    if (cmd_i.cap_mean) begin
      mean_q <= q_sgn[RES_W-1:0];
    end
    if (cmd_i.sqrt_ld) begin
      var_q <= VAR_W'(dq_q);
      sv_q  <= VAR_W'(dq_q);
      sr_q  <= '0;
      sb_q  <= SQRT_BIT0;
    end else if (cmd_i.sqrt_step) begin
      if (s_ge) begin
        sv_q <= sv_q - s_try;
        sr_q <= (sr_q >> 1) + sb_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sb_q <= sb_q >> 2;
    end
    if (cmd_i.out_ld) begin
      o_mean_q <= mean_q;
      o_min_q  <= lo_ext[RES_W-1:0];
      o_max_q  <= hi_ext[RES_W-1:0];
      o_var_q  <= var_q;
      o_sd_q   <= sr_q[RES_W-1:0];
    end
  end

endmodule

// ----- rtl/sample_statistics.sv -----
// ----------------------------------------------------------------------------
// sample_statistics
// Running mean, minimum, maximum, sample variance and standard deviation
// over sets of signed Q8.8 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel, one per cycle while s_axis_tready_o
//   is high. After sample_count samples (clamped to 2..MAX_COUNT) one result
//   request leaves on m_axis: mean, min, max (Q8.8), variance (Q16.16, n-1
//   divisor, floored) and std_dev (Q8.8, floored root).
//   The sample that closes a set drops s_axis_tready_o. The result then comes
//   from a product step, a one-bit-per-cycle restoring divider run twice
//   (mean, then variance), a 16-step square root, and the load of the output
//   register.
//   The output register holds a result while m_axis_tready_i is low; the next
//   set still accumulates, and only its own result waits for the register.
//   sample_count is written over the APB port at address 0; the user must do
//   so only while idle, which the block itself does not enforce.
//   Reset empties the set, drops m_axis_tvalid_o and sets sample_count to 5.
// ----------------------------------------------------------------------------
module sample_statistics #(
  parameter int MAX_COUNT    = sstat_pkg::MAX_COUNT_DEF,
  parameter int SAMPLE_WIDTH = sstat_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // sample input
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [sstat_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,  // [15:0] sample
  // result output
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [15:0] mean, [31:16] minimum, [47:32] maximum, [79:48] variance,
  // [95:80] std_dev
  output logic [sstat_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sstat_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sstat_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sstat_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import sstat_pkg::*;

  logic [CNT_W-1:0] sample_count_q;
  logic             reg_hit;
  logic             cfg_wr;

  sstat_cmd_t cmd;
  sstat_sts_t sts;

  logic [RES_W-1:0] mean, minimum, maximum, std_dev;
  logic [VAR_W-1:0] variance;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == CFG_IDX_SAMPLE_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? CFG_DATA_W'(sample_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= CNT_RESET;
    end else if (cfg_wr) begin
      sample_count_q <= pwdata[CNT_W-1:0];
    end
  end

  sstat_ctrl #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sstat_dp #(
    .MAX_COUNT    (MAX_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (s_axis_tdata_i),
    .sample_count_i (sample_count_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .mean_o         (mean),
    .minimum_o      (minimum),
    .maximum_o      (maximum),
    .variance_o     (variance),
    .std_dev_o      (std_dev)
  );

  assign m_axis_tdata_o = {std_dev, variance, maximum, minimum, mean};

endmodule

// ----- dv/sample_statistics_test.sv -----
// ----------------------------------------------------------------------------
// sample_statistics_test
// Self-checking bench for the sample statistics block. Directed sets cover
// field extremes, count clamping, register masking and a count lowered in
// mid-set. Random sets follow under several count settings and idle mixes,
// checked result by result against a bench-side model of the set arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_statistics_test;
  import sstat_pkg::*;

  localparam int          SETTLE_CYCLES = 100;
  localparam int          CYCLE_LIMIT   = 500_000;
  localparam int          RANDOM_ITEMS  = 250;
  localparam int unsigned SET_MAX       = MAX_COUNT_DEF;
  localparam logic [CFG_ADDR_W-1:0] CNT_ADDR = {CFG_IDX_SAMPLE_COUNT, 2'b00};

  // matches the m_axis tdata layout, mean in the low bits
  typedef struct packed {
    logic        [15:0] std_dev;
    logic        [31:0] variance;
    logic signed [15:0] maximum;
    logic signed [15:0] minimum;
    logic signed [15:0] mean;
  } stats_t;

  typedef enum logic [0:0] {
    OP_SAMPLE,
    OP_COUNT
  } row_op_e;

  typedef struct packed {
    row_op_e     op;
    logic [31:0] value;
    logic        typed;    // want holds the expected result of this row
    stats_t      want;
  } row_t;

  localparam stats_t HIGH_PAIR = '{mean: 16'h7FFF, minimum: 16'h7FFF, maximum: 16'h7FFF,
                                   variance: 32'h0, std_dev: 16'h0};
  localparam stats_t LOW_PAIR  = '{mean: 16'h8000, minimum: 16'h8000, maximum: 16'h8000,
                                   variance: 32'h0, std_dev: 16'h0};
  // sum -1 truncates to a zero mean; variance is 2 * 32767.5^2 floored
  localparam stats_t WIDE_PAIR = '{mean: 16'h0000, minimum: 16'h8000, maximum: 16'h7FFF,
                                   variance: 32'h7FFF_0000, std_dev: 16'hB504};

  localparam row_t DIRECTED[27] = '{
    // reset count of five
    '{OP_SAMPLE, 32'h0000_0100, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_FF00, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_0000, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_0001, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_FFFF, 1'b0, '0},
    // a count of zero acts as two
    '{OP_COUNT,  32'h0000_0000, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_7FFF, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_7FFF, 1'b1, HIGH_PAIR},
    '{OP_SAMPLE, 32'h0000_8000, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_8000, 1'b1, LOW_PAIR},
    '{OP_SAMPLE, 32'h0000_7FFF, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_8000, 1'b1, WIDE_PAIR},
    // a count of one acts as two
    '{OP_COUNT,  32'h0000_0001, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_8000, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_7FFF, 1'b1, WIDE_PAIR},
    // upper pwdata bits are dropped: count three
    '{OP_COUNT,  32'hFFFF_F803, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_0080, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_FF80, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_7FFF, 1'b0, '0},
    // count lowered to two with four samples held: next sample closes n = 5
    '{OP_COUNT,  32'h0000_0006, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_1234, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_EDCC, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_5555, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_AAAA, 1'b0, '0},
    '{OP_COUNT,  32'h0000_0002, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_0F0F, 1'b0, '0},
    '{OP_SAMPLE, 32'h0000_F0F0, 1'b0, '0}
  };

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [S_TDATA_W-1:0]  s_axis_tdata_i  = '0;   // [15:0] sample
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // [15:0] mean, [31:16] minimum, [47:32] maximum, [79:48] variance,
  // [95:80] std_dev
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // bench copy of the register and of the open set
  logic [CNT_W-1:0] samples_per_set = CNT_RESET;
  int unsigned      set_seen   = 0;
  longint           set_sum    = 0;
  longint unsigned  set_sum_sq = 0;
  longint           set_low    = 0;
  longint           set_high   = 0;

  stats_t      pending_stats[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic [15:0] phase_center   = '0;
  int unsigned mismatches     = 0;
  int unsigned samples_sent   = 0;
  int unsigned sets_checked   = 0;
  int unsigned count_writes   = 0;
  int unsigned cycles         = 0;

  sample_statistics u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycles,
               pending_stats.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic int unsigned set_target();
    int unsigned t;
    t = 32'(samples_per_set);
    if (t < 2) t = 2;
    if (t > SET_MAX) t = SET_MAX;
    return t;
  endfunction

  function automatic logic [15:0] floor_root(input logic [31:0] v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[15:0];
  endfunction

  // Adds one sample to the open set; returns 1 with the statistics when it
  // closes the set.
  function automatic logic fold_sample(input logic [15:0] raw, output stats_t res);
    longint          x;
    longint          n;
    longint          mean_q;
    longint unsigned mag;
    longint unsigned num;
    longint unsigned den;
    longint unsigned var_q;
    x   = longint'($signed(raw));
    res = '0;
    if (set_seen == 0) begin
      set_low  = x;
      set_high = x;
    end else begin
      if (x < set_low) set_low = x;
      if (x > set_high) set_high = x;
    end
    set_sum    += x;
    set_sum_sq += longint'(x * x);
    set_seen++;
    if (set_seen < set_target()) return 1'b0;
    n      = longint'(set_seen);
    mean_q = set_sum / n;                        // truncates toward zero
    mag    = (set_sum < 0) ? -set_sum : set_sum;
    num    = n * set_sum_sq - mag * mag;
    den    = n * (n - 1);
    var_q  = num / den;
    res.mean     = mean_q[15:0];
    res.minimum  = set_low[15:0];
    res.maximum  = set_high[15:0];
    res.variance = var_q[31:0];
    res.std_dev  = floor_root(var_q[31:0]);
    set_seen   = 0;
    set_sum    = 0;
    set_sum_sq = 0;
    set_low    = 0;
    set_high   = 0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    stats_t got;
    stats_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = stats_t'(m_axis_tdata_o);
      if (pending_stats.size() == 0) begin
        mismatches++;
        $error("result arrived with none pending: tdata %h", m_axis_tdata_o);
      end else begin
        want = pending_stats.pop_front();
        check_field("mean", want.mean, got.mean);
        check_field("minimum", want.minimum, got.minimum);
        check_field("maximum", want.maximum, got.maximum);
        check_field("variance", want.variance, got.variance);
        check_field("std_dev", want.std_dev, got.std_dev);
        sets_checked++;
      end
    end
  end

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom_range(0, 16'hFFFF));
      4, 5: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      // clustered around the phase center: small spreads, small roots
      default: return phase_center + 16'($urandom_range(0, 63)) - 16'd32;
    endcase
  endfunction

  task automatic push_sample(input logic [15:0] raw, input logic typed,
                             input stats_t typed_want);
    int unsigned gap;
    stats_t      res;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= raw;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    samples_sent++;
    if (fold_sample(raw, res)) pending_stats.push_back(typed ? typed_want : res);
  endtask

  // Register writes happen only with no result in flight and the block settled.
  task automatic write_count(input logic [31:0] value);
    s_axis_tvalid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CNT_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    samples_per_set = value[CNT_W-1:0];
    count_writes++;
  endtask

  task automatic set_idle_mix(input int unsigned mix);
    case (mix)
      1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
      3:       begin send_idle_pct = 38; recv_stall_pct = 38; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  initial begin : stimulus
    int unsigned random_start;
    int unsigned phase;
    int unsigned target;
    int unsigned items;
    logic [31:0] count_val;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].op == OP_COUNT) write_count(DIRECTED[i].value);
      else push_sample(DIRECTED[i].value[15:0], DIRECTED[i].typed, DIRECTED[i].want);
    end

    random_start = samples_sent;
    phase        = 0;
    while (samples_sent - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        17:      count_val = 32'd0;
        18:      count_val = 32'd1;
        19:      count_val = 32'hFFFF_F800 | $urandom_range(2, 4);
        13, 14, 15, 16: count_val = $urandom_range(9, 40);
        default: count_val = $urandom_range(2, 8);
      endcase
      write_count(count_val);
      set_idle_mix(phase % 5);
      target = set_target();
      items  = $urandom_range(1, 6) * target;
      // sometimes leave a partial set open across the next register write
      if ($urandom_range(0, 3) == 0) items += $urandom_range(1, target - 1);
      phase_center = 16'($urandom);
      repeat (items) push_sample(random_sample(), 1'b0, '0);
      phase++;
    end

    // register maximum clamps to the largest set: mostly minimum samples give
    // a near full-width sum together with a wide spread
    write_count(32'h0000_07FF);
    set_idle_mix(0);
    repeat (SET_MAX - set_seen) push_sample(($urandom_range(0, 7) == 0) ? 16'h7FFF : 16'h8000,
                                            1'b0, '0);

    s_axis_tvalid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples, checked %0d result sets over %0d count writes,", samples_sent,
             sets_checked, count_writes);
    $display("with set sizes from clamped 2 up to %0d and mixed sender/receiver idling.",
             SET_MAX);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sample_statistics.f -----
rtl/sstat_pkg.sv
rtl/sstat_ctrl.sv
rtl/sstat_dp.sv
rtl/sample_statistics.sv
dv/sample_statistics_test.sv
